// File: sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; clocked on clk, disabled in rst.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define QAU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define QAU_NEVER(lbl, cond, msg) \
  `QAU_ASSERT(lbl, !(cond), msg)
`else
`define QAU_ASSERT(lbl, prop, msg)
`define QAU_NEVER(lbl, cond, msg)
`endif
`endif

// File: sv/qau_pkg.sv
// ---------------------------------------------------------------------------
// qau_pkg
// Types, codes and fixed-point helpers of the quaternion arithmetic unit.
// ---------------------------------------------------------------------------
`default_nettype none
package qau_pkg;

  localparam logic [2:0] ACT_ADD   = 3'd0;
  localparam logic [2:0] ACT_SUB   = 3'd1;
  localparam logic [2:0] ACT_HAM   = 3'd2;
  localparam logic [2:0] ACT_SCALE = 3'd3;
  localparam logic [2:0] ACT_MAG   = 3'd4;

  localparam int QUEUE_DEPTH = 2;
  localparam int RAD_W       = 62;          // radicand width, sums below 2^62
  localparam int ROOT_W      = RAD_W + 1;
  localparam int SQRT_STEPS  = RAD_W / 2;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef logic signed [31:0] qau_word_t;

  typedef struct packed {
    logic [2:0] action;
    qau_word_t  a_w;
    qau_word_t  a_x;
    qau_word_t  a_y;
    qau_word_t  a_z;
    qau_word_t  b_w;
    qau_word_t  b_x;
    qau_word_t  b_y;
    qau_word_t  b_z;
    qau_word_t  scale_factor;
  } qau_req_t;

  typedef struct packed {
    qau_word_t r_w;
    qau_word_t r_x;
    qau_word_t r_y;
    qau_word_t r_z;
    logic      overflow;
  } qau_rsp_t;

  typedef enum logic [5:0] {
    K_ADD   = 6'b000001,
    K_SUB   = 6'b000010,
    K_HAM   = 6'b000100,
    K_SCALE = 6'b001000,
    K_MAG   = 6'b010000,
    K_NONE  = 6'b100000
  } qau_kind_t;

  // index 0 is w, then x, y, z
  typedef struct packed {
    qau_kind_t       kind;
    qau_word_t [3:0] a;
    qau_word_t [3:0] b;   // multiplier operands, already selected
  } qau_job_t;

  typedef struct packed {
    logic     valid;
    qau_job_t job;
  } qau_slot_t;

  typedef struct packed {
    logic            is_mag;
    logic            big;
    qau_word_t [3:0] r;
    logic            ov;
  } qau_side_t;

  // {overflow, value}
  function automatic logic [32:0] sat67(input logic signed [66:0] v);
    logic [32:0] res;
    if (v > 67'sd2147483647) begin
      res = {1'b1, Q_MAX};
    end else if (v < -67'sd2147483648) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  // Q32.32 sum to Q16.16, round half up, then saturate
  function automatic logic [32:0] round_sat(input logic signed [65:0] t);
    logic signed [66:0] sum;
    logic signed [66:0] q;
    sum = $signed({t[65], t}) + 67'sd32768;
    q   = sum >>> 16;
    return sat67(q);
  endfunction

  function automatic logic [32:0] sat33(input logic [32:0] v);
    return sat67($signed({{34{v[32]}}, v}));
  endfunction

endpackage
`default_nettype wire

// File: sv/qau_front.sv
// ---------------------------------------------------------------------------
// qau_front
// Takes requests, decodes the action and selects the multiplier operands.
// ---------------------------------------------------------------------------
`default_nettype none
module qau_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qau_pkg::qau_req_t request,
  input  logic              q_ready,
  output qau_pkg::qau_slot_t push
);

  logic              front_valid;
  qau_pkg::qau_job_t job;
  qau_pkg::qau_job_t job_next;
  logic              take;

  assign busy = front_valid && !q_ready;
  assign take = start && !busy;

  always_comb begin
    job_next.a = {request.a_z, request.a_y, request.a_x, request.a_w};
    job_next.b = {request.b_z, request.b_y, request.b_x, request.b_w};
    case (request.action)
      qau_pkg::ACT_ADD:   job_next.kind = qau_pkg::K_ADD;
      qau_pkg::ACT_SUB:   job_next.kind = qau_pkg::K_SUB;
      qau_pkg::ACT_HAM:   job_next.kind = qau_pkg::K_HAM;
      qau_pkg::ACT_SCALE: begin
        job_next.kind = qau_pkg::K_SCALE;
        job_next.b    = {4{request.scale_factor}};
      end
      qau_pkg::ACT_MAG: begin
        // squares come off the diagonal products
        job_next.kind = qau_pkg::K_MAG;
        job_next.b    = job_next.a;
      end
      default:            job_next.kind = qau_pkg::K_NONE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front_valid <= 1'b0;
    end else if (take) begin
      front_valid <= 1'b1;
    end else if (q_ready) begin
      front_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      job <= job_next;
    end
  end

  assign push.valid = front_valid;
  assign push.job   = job;

endmodule
`default_nettype wire

// File: sv/qau_queue.sv
// ---------------------------------------------------------------------------
// qau_queue
// Short queue between decode and execute; execute drains it every cycle.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module qau_queue #(
  parameter int DEPTH = qau_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  qau_pkg::qau_slot_t push,
  output logic               ready,
  output qau_pkg::qau_slot_t head
);

  localparam int PW = $clog2(DEPTH);

  qau_pkg::qau_job_t store [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign ready   = count != (PW+1)'(DEPTH);
  assign do_push = push.valid && ready;
  assign do_pop  = count != '0;

  always_ff @(posedge clk) begin
    if (do_push) begin
      store[wr_ptr] <= push.job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (!do_push && do_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  assign head.valid = do_pop;
  assign head.job   = store[rd_ptr];

  `QAU_NEVER(q_no_overrun, push.valid && ready && count == (PW+1)'(DEPTH), "queue overrun")
  `QAU_ASSERT(q_count_bound, count <= (PW+1)'(DEPTH), "queue count out of range")
  `QAU_ASSERT(q_fill, do_push && !do_pop |=> count == $past(count) + 1'b1, "queue fill lost")

endmodule
`default_nettype wire

// File: sv/qau_sqrt.sv
// ---------------------------------------------------------------------------
// qau_sqrt
// Pipelined restoring square root, one result bit per stage, rounded.
// ---------------------------------------------------------------------------
`default_nettype none
module qau_sqrt (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [qau_pkg::RAD_W-1:0] radicand,
  input  qau_pkg::qau_side_t      in_side,
  output logic                    out_valid,
  output logic [31:0]             root,
  output qau_pkg::qau_side_t      out_side
);

  localparam int N  = qau_pkg::SQRT_STEPS;
  localparam int RW = qau_pkg::RAD_W;
  localparam int TW = qau_pkg::ROOT_W;

  logic               vld  [1:N];
  logic [RW-1:0]      rem  [1:N];
  logic [TW-1:0]      acc  [1:N];
  qau_pkg::qau_side_t side [1:N];

  for (genvar k = 0; k < N; k++) begin : g_step
    localparam logic [TW-1:0] BIT = TW'(1) << (2 * (N - 1 - k));
    logic               cur_vld;
    logic [RW-1:0]      cur_rem;
    logic [TW-1:0]      cur_acc;
    qau_pkg::qau_side_t cur_side;
    logic [TW-1:0]      trial;
    logic               fits;

    if (k == 0) begin : g_first
      assign cur_vld  = in_valid;
      assign cur_rem  = radicand;
      assign cur_acc  = '0;
      assign cur_side = in_side;
    end else begin : g_next
      assign cur_vld  = vld[k];
      assign cur_rem  = rem[k];
      assign cur_acc  = acc[k];
      assign cur_side = side[k];
    end

    assign trial = cur_acc + BIT;
    assign fits  = {1'b0, cur_rem} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= cur_vld;
      end
    end

    always_ff @(posedge clk) begin
      side[k+1] <= cur_side;
      if (fits) begin
        rem[k+1] <= cur_rem - trial[RW-1:0];
        acc[k+1] <= (cur_acc >> 1) + BIT;
      end else begin
        rem[k+1] <= cur_rem;
        acc[k+1] <= cur_acc >> 1;
      end
    end
  end

  // round to nearest; a tie cannot occur
  assign out_valid = vld[N];
  assign out_side  = side[N];
  assign root      = acc[N][31:0] + 32'({1'b0, rem[N]} > acc[N]);

endmodule
`default_nettype wire

// File: sv/qau_back.sv
// ---------------------------------------------------------------------------
// qau_back
// Execute pipeline: products, sums, round and saturate, root, result.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module qau_back (
  input  logic               clk,
  input  logic               rst,
  input  qau_pkg::qau_slot_t head,
  output logic               result_valid,
  output qau_pkg::qau_rsp_t  result
);

  localparam int LAT = 4 + qau_pkg::SQRT_STEPS;

  function automatic logic signed [65:0] x66(input logic [63:0] v);
    return $signed({{2{v[63]}}, v});
  endfunction

  // stage 1: products and add/subtract
  logic               s1_valid;
  qau_pkg::qau_kind_t s1_kind;
  logic signed [63:0] p [4][4];
  logic [32:0]        as1 [4];

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= head.valid;
  end

  always_ff @(posedge clk) begin
    s1_kind <= head.job.kind;
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        p[i][j] <= $signed(head.job.a[i]) * $signed(head.job.b[j]);
      end
      if (head.job.kind == qau_pkg::K_SUB) begin
        as1[i] <= {head.job.a[i][31], head.job.a[i]} - {head.job.b[i][31], head.job.b[i]};
      end else begin
        as1[i] <= {head.job.a[i][31], head.job.a[i]} + {head.job.b[i][31], head.job.b[i]};
      end
    end
  end

  // stage 2: exact sums
  logic               s2_valid;
  qau_pkg::qau_kind_t s2_kind;
  logic signed [65:0] t2 [4];
  logic signed [65:0] t2_next [4];
  logic [64:0]        msum;
  logic [32:0]        as2 [4];

  always_comb begin
    for (int i = 0; i < 4; i++) t2_next[i] = '0;
    case (s1_kind)
      qau_pkg::K_HAM: begin
        t2_next[0] = x66(p[0][0]) - x66(p[1][1]) - x66(p[2][2]) - x66(p[3][3]);
        t2_next[1] = x66(p[0][1]) + x66(p[1][0]) + x66(p[2][3]) - x66(p[3][2]);
        t2_next[2] = x66(p[0][2]) - x66(p[1][3]) + x66(p[2][0]) + x66(p[3][1]);
        t2_next[3] = x66(p[0][3]) + x66(p[1][2]) - x66(p[2][1]) + x66(p[3][0]);
      end
      qau_pkg::K_SCALE: begin
        for (int i = 0; i < 4; i++) t2_next[i] = x66(p[i][i]);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else     s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    s2_kind <= s1_kind;
    t2      <= t2_next;
    as2     <= as1;
    msum    <= {1'b0, p[0][0]} + {1'b0, p[1][1]} + {1'b0, p[2][2]} + {1'b0, p[3][3]};
  end

  // stage 3: round and saturate
  logic                        s3_valid;
  qau_pkg::qau_side_t          s3_side;
  qau_pkg::qau_side_t          s3_side_next;
  logic [qau_pkg::RAD_W-1:0]   s3_rad;
  logic [32:0]                 sat_v [4];

  always_comb begin
    for (int i = 0; i < 4; i++) sat_v[i] = '0;
    case (s2_kind)
      qau_pkg::K_ADD, qau_pkg::K_SUB: begin
        for (int i = 0; i < 4; i++) sat_v[i] = qau_pkg::sat33(as2[i]);
      end
      qau_pkg::K_HAM, qau_pkg::K_SCALE: begin
        for (int i = 0; i < 4; i++) sat_v[i] = qau_pkg::round_sat(t2[i]);
      end
      default: ;
    endcase
    s3_side_next.is_mag = s2_kind == qau_pkg::K_MAG;
    s3_side_next.big    = |msum[64:qau_pkg::RAD_W];
    s3_side_next.ov     = sat_v[0][32] | sat_v[1][32] | sat_v[2][32] | sat_v[3][32];
    for (int i = 0; i < 4; i++) s3_side_next.r[i] = sat_v[i][31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else     s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    s3_side <= s3_side_next;
    s3_rad  <= msum[qau_pkg::RAD_W-1:0];
  end

  // root stages
  logic               sq_valid;
  logic [31:0]        sq_root;
  qau_pkg::qau_side_t sq_side;

  qau_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s3_valid),
    .radicand (s3_rad),
    .in_side  (s3_side),
    .out_valid(sq_valid),
    .root     (sq_root),
    .out_side (sq_side)
  );

  // result register
  qau_pkg::qau_rsp_t rsp_next;
  logic              mag_sat;
  logic              o_mag;

  assign mag_sat = sq_side.big || sq_root[31];

  always_comb begin
    if (sq_side.is_mag) begin
      rsp_next.r_w      = mag_sat ? qau_pkg::Q_MAX : sq_root;
      rsp_next.r_x      = '0;
      rsp_next.r_y      = '0;
      rsp_next.r_z      = '0;
      rsp_next.overflow = mag_sat;
    end else begin
      rsp_next.r_w      = sq_side.r[0];
      rsp_next.r_x      = sq_side.r[1];
      rsp_next.r_y      = sq_side.r[2];
      rsp_next.r_z      = sq_side.r[3];
      rsp_next.overflow = sq_side.ov;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else     result_valid <= sq_valid;
  end

  always_ff @(posedge clk) begin
    result <= rsp_next;
    o_mag  <= sq_side.is_mag;
  end

  `QAU_ASSERT(bk_latency, head.valid |-> ##LAT result_valid, "result strobe missing")
  `QAU_ASSERT(bk_mag_xyz, result_valid && o_mag |-> result.r_x == '0 && result.r_y == '0 && result.r_z == '0, "magnitude with vector part")
  `QAU_ASSERT(bk_ov_sat, result_valid && result.overflow && !o_mag |-> result.r_w == qau_pkg::Q_MAX || result.r_w == qau_pkg::Q_MIN || result.r_x == qau_pkg::Q_MAX || result.r_x == qau_pkg::Q_MIN || result.r_y == qau_pkg::Q_MAX || result.r_y == qau_pkg::Q_MIN || result.r_z == qau_pkg::Q_MAX || result.r_z == qau_pkg::Q_MIN, "overflow without saturated part")

endmodule
`default_nettype wire

// File: sv/quaternion_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Quaternion add, subtract, Hamilton product, scale and magnitude, Q16.16.
// ---------------------------------------------------------------------------
// Usage:
//   A request (action, A, B, scale_factor) is taken at a rising edge with
//   start high and busy low. One result per request comes back on result,
//   marked by result_valid for exactly one cycle, in request order.
//   Path: a taken request passes the decode register, the queue, three
//   arithmetic stages, 31 root stages and the result register, in that
//   order, before result_valid rises. The root pipeline is its longest part.
//   Throughput: one request per cycle unless busy; every action runs the
//   same pipeline. busy only rises if the queue fills, which the execute
//   side, draining one entry per cycle, does not allow in normal running.
//   The receiver cannot stall: results are shown once and not held.
//   Reset (rst, synchronous) empties the queue and pipeline; requests in
//   flight are dropped. Results saturate to Q16.16 and raise overflow.
// ---------------------------------------------------------------------------
`default_nettype none
module quaternion_arithmetic_unit #(
  parameter int QUEUE_DEPTH = qau_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qau_pkg::qau_req_t request,
  output logic              result_valid,
  output qau_pkg::qau_rsp_t result
);

  qau_pkg::qau_slot_t push;
  qau_pkg::qau_slot_t head;
  logic               q_ready;

  qau_front u_front (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .request(request),
    .q_ready(q_ready),
    .push   (push)
  );

  qau_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .ready(q_ready),
    .head (head)
  );

  qau_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule
`default_nettype wire

// File: test/tb_quaternion_arithmetic_unit.sv
// ---------------------------------------------------------------------------
// tb_quaternion_arithmetic_unit
// Self-checking bench: drives random and corner-case requests through the
// unit and compares each result, in order, with an exact quaternion model.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none
module tb_quaternion_arithmetic_unit;

  localparam int LATENCY = 40;
  localparam longint CYCLE_LIMIT = 400000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  qau_pkg::qau_req_t request = '0;
  logic              result_valid;
  qau_pkg::qau_rsp_t result;

  int     errors = 0;
  longint cycles = 0;

  quaternion_arithmetic_unit uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .request(request), .result_valid(result_valid), .result(result)
  );

  always #10 clk = ~clk;

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // saturate a wide value to Q16.16
  function automatic logic signed [31:0] clamp(input logic signed [69:0] v, ref logic ov);
    if (v > 70'sd2147483647) begin
      ov = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -70'sd2147483648) begin
      ov = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  // exact Q32.32 sum, round half up to Q16.16 (arithmetic shift floors)
  function automatic logic signed [31:0] round_q(input logic signed [69:0] s, ref logic ov);
    logic signed [69:0] q;
    q = (s + 70'sd32768) >>> 16;
    return clamp(q, ov);
  endfunction

  function automatic logic signed [69:0] mul(input qau_pkg::qau_word_t x,
                                             input qau_pkg::qau_word_t y);
    logic signed [69:0] p;
    p = 70'(x) * 70'(y);
    return p;
  endfunction

  function automatic logic [63:0] root_nearest(input logic [63:0] s);
    logic [63:0] r, lo, hi, mid;
    lo = 0;
    hi = 64'd2147483648;
    while (lo < hi) begin
      mid = (lo + hi + 1) >> 1;
      if (mid * mid <= s) lo = mid;
      else hi = mid - 1;
    end
    r = lo;
    // nearest: compare s with (r+0.5)^2 = r*r + r + 0.25
    if (s - r * r > r) r = r + 1;
    return r;
  endfunction

  function automatic qau_pkg::qau_rsp_t quat_compute(input qau_pkg::qau_req_t q);
    qau_pkg::qau_rsp_t r;
    logic ov;
    logic [65:0] sum;
    logic [63:0] m;
    qau_pkg::qau_word_t a[4], b[4];
    r = '0;
    ov = 1'b0;
    a = '{q.a_w, q.a_x, q.a_y, q.a_z};
    b = '{q.b_w, q.b_x, q.b_y, q.b_z};
    case (q.action)
      qau_pkg::ACT_ADD: begin
        r.r_w = clamp(70'(a[0]) + 70'(b[0]), ov);
        r.r_x = clamp(70'(a[1]) + 70'(b[1]), ov);
        r.r_y = clamp(70'(a[2]) + 70'(b[2]), ov);
        r.r_z = clamp(70'(a[3]) + 70'(b[3]), ov);
      end
      qau_pkg::ACT_SUB: begin
        r.r_w = clamp(70'(a[0]) - 70'(b[0]), ov);
        r.r_x = clamp(70'(a[1]) - 70'(b[1]), ov);
        r.r_y = clamp(70'(a[2]) - 70'(b[2]), ov);
        r.r_z = clamp(70'(a[3]) - 70'(b[3]), ov);
      end
      qau_pkg::ACT_HAM: begin
        r.r_w = round_q(mul(a[0], b[0]) - mul(a[1], b[1]) - mul(a[2], b[2])
                        - mul(a[3], b[3]), ov);
        r.r_x = round_q(mul(a[0], b[1]) + mul(a[1], b[0]) + mul(a[2], b[3])
                        - mul(a[3], b[2]), ov);
        r.r_y = round_q(mul(a[0], b[2]) - mul(a[1], b[3]) + mul(a[2], b[0])
                        + mul(a[3], b[1]), ov);
        r.r_z = round_q(mul(a[0], b[3]) + mul(a[1], b[2]) - mul(a[2], b[1])
                        + mul(a[3], b[0]), ov);
      end
      qau_pkg::ACT_SCALE: begin
        r.r_w = round_q(mul(a[0], q.scale_factor), ov);
        r.r_x = round_q(mul(a[1], q.scale_factor), ov);
        r.r_y = round_q(mul(a[2], q.scale_factor), ov);
        r.r_z = round_q(mul(a[3], q.scale_factor), ov);
      end
      qau_pkg::ACT_MAG: begin
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          m = a[i] < 0 ? 64'(-70'(a[i])) : 64'(a[i]);
          sum += 66'(m * m);
        end
        if (sum >= 66'h1_0000_0000_0000_0000 >> 2) begin
          r.r_w = 32'sh7FFF_FFFF;
          ov = 1'b1;
        end else begin
          r.r_w = clamp(70'(root_nearest(sum[63:0])), ov);
        end
      end
      default: ;
    endcase
    r.overflow = ov;
    return r;
  endfunction

  class quat_scoreboard;
    qau_pkg::qau_rsp_t pending[$];

    function void note_request(qau_pkg::qau_req_t q);
      pending.push_back(quat_compute(q));
    endfunction

    task check_result(qau_pkg::qau_rsp_t got);
      qau_pkg::qau_rsp_t want;
      if (pending.size() == 0) begin
        report("unexpected result", got.r_w, 32'h0);
        return;
      end
      want = pending.pop_front();
      if (got.r_w !== want.r_w) report("r_w", got.r_w, want.r_w);
      if (got.r_x !== want.r_x) report("r_x", got.r_x, want.r_x);
      if (got.r_y !== want.r_y) report("r_y", got.r_y, want.r_y);
      if (got.r_z !== want.r_z) report("r_z", got.r_z, want.r_z);
      if (got.overflow !== want.overflow)
        report("overflow", 32'(got.overflow), 32'(want.overflow));
    endtask
  endclass

  quat_scoreboard results_due = new();

  always @(posedge clk) begin
    cycles++;
    if (!rst && result_valid) results_due.check_result(result);
    if (!rst && start && !busy) results_due.note_request(request);
    if (cycles > CYCLE_LIMIT) begin
      $display("quaternion_arithmetic_unit test failed");
      $finish;
    end
  end

  function automatic qau_pkg::qau_word_t pick_word(input int mode);
    case (mode)
      0: return $urandom();
      1: return 32'sh8000_0000;
      2: return 32'sh7FFF_FFFF;
      3: return 32'sh0001_0000;
      4: return -32'sh0001_0000;
      5: return $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000;
      6: return 32'sh0000_8000;
      default: return $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
    endcase
  endfunction

  // start stays high into the next request when there is no gap
  task automatic send(input qau_pkg::qau_req_t q, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    request <= q;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    wait (results_due.pending.size() == 0);
  endtask

  task automatic send_random(input int gap);
    qau_pkg::qau_req_t q;
    int m;
    m = $urandom_range(0, 7);
    q.action = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                            : 3'($urandom_range(0, 4));
    q.a_w = pick_word(m > 4 ? $urandom_range(0, 7) : m);
    q.a_x = pick_word(m > 4 ? $urandom_range(0, 7) : m);
    q.a_y = pick_word(m > 4 ? $urandom_range(0, 7) : m);
    q.a_z = pick_word(m > 4 ? $urandom_range(0, 7) : m);
    q.b_w = pick_word($urandom_range(0, 7));
    q.b_x = pick_word($urandom_range(0, 7));
    q.b_y = pick_word($urandom_range(0, 7));
    q.b_z = pick_word($urandom_range(0, 7));
    q.scale_factor = pick_word($urandom_range(0, 7));
    send(q, gap);
  endtask

  initial begin
    qau_pkg::qau_req_t q;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, each action, unused codes, half-way rounding
    for (int act = 0; act < 8; act++) begin
      q = '{action: 3'(act), a_w: 32'sh7FFF_FFFF, a_x: 32'sh8000_0000,
            a_y: 32'sh7FFF_FFFF, a_z: 32'sh8000_0000, b_w: 32'sh7FFF_FFFF,
            b_x: 32'sh7FFF_FFFF, b_y: 32'sh8000_0000, b_z: 32'sh8000_0000,
            scale_factor: 32'sh8000_0000};
      send(q, 0);
    end
    for (int act = 0; act < 5; act++) begin
      q = '{action: 3'(act), a_w: 32'sh0001_0000, a_x: 32'sh0000_8000,
            a_y: -32'sh0000_8000, a_z: 32'sh0000_0001, b_w: 32'sh0000_0001,
            b_x: 32'sh0000_8000, b_y: 32'sh0001_0000, b_z: -32'sh0001_0000,
            scale_factor: 32'sh0000_8000};
      send(q, 1);
    end
    q = '0; q.action = qau_pkg::ACT_MAG; send(q, 0);
    q.a_w = 32'sh0000_0003; q.a_x = 32'sh0000_0004; send(q, 0);
    q.a_w = 32'sh8000_0000; q.a_x = 32'sh0; send(q, 0);
    q.action = qau_pkg::ACT_SCALE; q.a_w = 32'sh8000_0000;
    q.scale_factor = -32'sh0001_0000;
    send(q, 0);

    // hold off until the unit has drained
    drain();
    @(posedge clk);

    for (int n = 0; n < 1500; n++) begin
      if ((n / 300) % 2 == 0) send_random(0);
      else send_random($urandom_range(0, 10));
    end

    drain();
    repeat (LATENCY) @(posedge clk);
    if (errors == 0) begin
      $display("quaternion_arithmetic_unit test passed");
    end else begin
      $display("quaternion_arithmetic_unit test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
